// File: src/clf_pkg.sv
// ----------------------------------------------------------------------------
// clf_pkg
// Shared constants and types for the CR/LF line framer.
// ----------------------------------------------------------------------------
`default_nettype none

package clf_pkg;

    localparam int BYTE_W       = 8;
    localparam int FRAME_LEN_W  = 5;
    localparam int MAX_LINE_DEF = 31;

    localparam logic [BYTE_W-1:0] CHAR_CR = 8'h0D;
    localparam logic [BYTE_W-1:0] CHAR_LF = 8'h0A;

    typedef enum logic [1:0] {
        ST_COLLECT = 2'b01,
        ST_EMIT    = 2'b10
    } state_t;

    function automatic logic is_term(input logic [BYTE_W-1:0] c);
        return (c == CHAR_CR) || (c == CHAR_LF);
    endfunction

endpackage

`default_nettype wire

// File: src/clf_line_ram.sv
// ----------------------------------------------------------------------------
// clf_line_ram
// Line store: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module clf_line_ram #(
    parameter int DEPTH = clf_pkg::MAX_LINE_DEF,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic                       clk,
    input  wire logic                       wr_en,
    input  wire logic [ADDR_W-1:0]          wr_addr,
    input  wire logic [clf_pkg::BYTE_W-1:0] wr_data,
    input  wire logic                       rd_en,
    input  wire logic [ADDR_W-1:0]          rd_addr,
    output logic      [clf_pkg::BYTE_W-1:0] rd_data
);
    import clf_pkg::*;

    logic [BYTE_W-1:0] store_mem [0:DEPTH-1];
    logic [BYTE_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            store_mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= store_mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

// File: src/crlf_line_framer.sv
// ----------------------------------------------------------------------------
// crlf_line_framer
// Collects received bytes into a line store and, on CR or LF, sends the
// held line out word by word with the last word marked.
// ----------------------------------------------------------------------------
//  channel  | direction | handshake            | payload
//  rx       | in        | rx_valid / rx_stall  | rx_byte
//  frame    | out       | frame_valid / stall  | frame_byte, frame_last,
//           |           |                      | frame_length, overflow
//
//  A data byte or an ignored terminator is taken without stalling rx.
//  A terminator ending an n-byte line stalls rx while the n bytes of the
//  store are read out, one read a cycle; frame_stall slows the read-out.
//  Read data of the store is the frame output register.
//  Reset clears the held count, overflow flag and control; no clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none

module crlf_line_framer #(
    parameter int MAX_LINE = clf_pkg::MAX_LINE_DEF
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           rx_valid,
    output logic                                rx_stall,
    input  wire logic [clf_pkg::BYTE_W-1:0]     rx_byte,
    output logic                                frame_valid,
    input  wire logic                           frame_stall,
    output logic      [clf_pkg::BYTE_W-1:0]     frame_byte,
    output logic                                frame_last,
    output logic      [clf_pkg::FRAME_LEN_W-1:0] frame_length,
    output logic                                overflow
);
    import clf_pkg::*;

    localparam int CNT_W  = $clog2(MAX_LINE + 1);
    localparam int ADDR_W = (MAX_LINE > 1) ? $clog2(MAX_LINE) : 1;

    state_t             state_reg, state_next;
    logic [CNT_W-1:0]   held_reg, held_next;
    logic               ovf_reg, ovf_next;
    logic [CNT_W-1:0]   line_len_reg, line_len_next;
    logic               line_ovf_reg, line_ovf_next;
    logic [ADDR_W-1:0]  rd_idx_reg, rd_idx_next;
    logic               frame_valid_reg, frame_valid_next;
    logic               frame_last_reg;
    logic [FRAME_LEN_W-1:0] frame_length_reg;
    logic               overflow_reg;

    logic               rx_take;
    logic               rx_term;
    logic               has_room;
    logic               wr_en;
    logic               issue;
    logic               rd_last;
    logic [CNT_W-1:0]   len_m1;

    assign rx_stall = (state_reg != ST_COLLECT);
    assign rx_take  = rx_valid && !rx_stall;
    assign rx_term  = is_term(rx_byte);
    assign has_room = (held_reg < CNT_W'(MAX_LINE));
    assign wr_en    = rx_take && !rx_term && has_room;

    assign issue   = (state_reg == ST_EMIT) && (!frame_valid_reg || !frame_stall);
    assign len_m1  = line_len_reg - CNT_W'(1);
    assign rd_last = (rd_idx_reg == len_m1[ADDR_W-1:0]);

    clf_line_ram #(
        .DEPTH  (MAX_LINE),
        .ADDR_W (ADDR_W)
    ) u_line_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (held_reg[ADDR_W-1:0]),
        .wr_data (rx_byte),
        .rd_en   (issue),
        .rd_addr (rd_idx_reg),
        .rd_data (frame_byte)
    );

    always_comb
    begin
        state_next       = state_reg;
        held_next        = held_reg;
        ovf_next         = ovf_reg;
        line_len_next    = line_len_reg;
        line_ovf_next    = line_ovf_reg;
        rd_idx_next      = rd_idx_reg;
        frame_valid_next = frame_valid_reg;

        if (issue)
        begin
            frame_valid_next = 1'b1;
        end
        else if (!frame_stall)
        begin
            frame_valid_next = 1'b0;
        end

        case (state_reg)
            ST_COLLECT:
            begin
                if (rx_take)
                begin
                    if (!rx_term)
                    begin
                        if (has_room)
                        begin
                            held_next = held_reg + CNT_W'(1);
                        end
                        else
                        begin
                            ovf_next = 1'b1;
                        end
                    end
                    else if (held_reg != '0)
                    begin
                        line_len_next = held_reg;
                        line_ovf_next = ovf_reg;
                        held_next     = '0;
                        ovf_next      = 1'b0;
                        rd_idx_next   = '0;
                        state_next    = ST_EMIT;
                    end
                end
            end
            ST_EMIT:
            begin
                if (issue)
                begin
                    rd_idx_next = rd_idx_reg + ADDR_W'(1);
                    if (rd_last)
                    begin
                        state_next = ST_COLLECT;
                    end
                end
            end
            default:
            begin
                state_next = ST_COLLECT;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_COLLECT;
            held_reg        <= '0;
            ovf_reg         <= 1'b0;
            line_len_reg    <= '0;
            line_ovf_reg    <= 1'b0;
            rd_idx_reg      <= '0;
            frame_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            held_reg        <= held_next;
            ovf_reg         <= ovf_next;
            line_len_reg    <= line_len_next;
            line_ovf_reg    <= line_ovf_next;
            rd_idx_reg      <= rd_idx_next;
            frame_valid_reg <= frame_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (issue)
        begin
            frame_last_reg   <= rd_last;
            frame_length_reg <= FRAME_LEN_W'(line_len_reg);
            overflow_reg     <= line_ovf_reg;
        end
    end

    assign frame_valid  = frame_valid_reg;
    assign frame_last   = frame_last_reg;
    assign frame_length = frame_length_reg;
    assign overflow     = overflow_reg;

    a_held_bound: assert property (@(posedge clk) disable iff (!rst_n)
        held_reg <= CNT_W'(MAX_LINE))
        else $error("held count beyond line capacity");

    a_last_returns: assert property (@(posedge clk) disable iff (!rst_n)
        issue && rd_last |=> state_reg == ST_COLLECT && frame_last)
        else $error("last read did not end the frame");

    a_emit_len: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_EMIT |-> line_len_reg != '0)
        else $error("emitting an empty line");

endmodule

`default_nettype wire

// File: test/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Testbench for crlf_line_framer. Received bytes are sent one word at a time
// on the rx channel while a line predictor tracks the held bytes. Each
// completed line is turned into expected frame words. Every word taken from
// the frame channel is checked field by field against the oldest expected
// word. Both channels insert random idle cycles, with stretches of none.
// ----------------------------------------------------------------------------

module tb_top;

    import clf_pkg::*;

    localparam int MAX_LINE    = MAX_LINE_DEF;
    localparam int CYCLE_LIMIT = 200000;
    localparam int RAND_ITEMS  = 80;

    typedef struct packed {
        logic [BYTE_W-1:0]      data;
        logic                   last;
        logic [FRAME_LEN_W-1:0] len;
        logic                   ovf;
    } frame_word_t;

    logic                   clk;
    logic                   rst_n;
    logic                   rx_valid;
    logic                   rx_stall;
    logic [BYTE_W-1:0]      rx_byte;
    logic                   frame_valid;
    logic                   frame_stall;
    logic [BYTE_W-1:0]      frame_byte;
    logic                   frame_last;
    logic [FRAME_LEN_W-1:0] frame_length;
    logic                   overflow;

    frame_word_t       expected_words[$];
    logic [BYTE_W-1:0] line_store [MAX_LINE];
    int                held_count;
    logic              overflowed;
    int                taken_items;
    int                fail_count;
    int                cycle_count;
    logic              rx_no_gap;
    logic              sink_no_gap;

    crlf_line_framer #(
        .MAX_LINE(MAX_LINE)
    ) i_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .rx_valid    (rx_valid),
        .rx_stall    (rx_stall),
        .rx_byte     (rx_byte),
        .frame_valid (frame_valid),
        .frame_stall (frame_stall),
        .frame_byte  (frame_byte),
        .frame_last  (frame_last),
        .frame_length(frame_length),
        .overflow    (overflow)
    );

    always
    begin
        clk = 1'b0;
        #1;
        clk = 1'b1;
        #1;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    function automatic logic [BYTE_W-1:0] random_data_byte();
        logic [BYTE_W-1:0] c;
        do
            c = BYTE_W'($urandom_range(0, 255));
        while (c == CHAR_CR || c == CHAR_LF);
        return c;
    endfunction

    task automatic predict_frame_words(input logic [BYTE_W-1:0] c);
        frame_word_t w;
        int          k;
        if (c != CHAR_CR && c != CHAR_LF)
        begin
            if (held_count < MAX_LINE)
            begin
                line_store[held_count] = c;
                held_count++;
            end
            else
            begin
                overflowed = 1'b1;
            end
            taken_items++;
        end
        else if (held_count != 0)
        begin
            for (k = 0; k < held_count; k++)
            begin
                w.data = line_store[k];
                w.last = (k + 1 == held_count);
                w.len  = FRAME_LEN_W'(held_count);
                w.ovf  = overflowed;
                expected_words.push_back(w);
            end
            held_count = 0;
            overflowed = 1'b0;
            taken_items++;
        end
    endtask

    task automatic send_byte(input logic [BYTE_W-1:0] c);
        int   gap;
        logic acc;
        gap = rx_no_gap ? 0 : $urandom_range(0, 5);
        if (gap > 0)
        begin
            rx_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        rx_valid <= 1'b1;
        rx_byte  <= c;
        do
        begin
            @(negedge clk);
            acc = (rx_stall === 1'b0);
            @(posedge clk);
        end
        while (!acc);
        predict_frame_words(c);
    endtask

    task automatic send_line(input int len, input logic [BYTE_W-1:0] term);
        int i;
        for (i = 0; i < len; i++)
            send_byte(random_data_byte());
        send_byte(term);
    endtask

    // drive frame_stall: insert a random stall before each word is taken
    initial
    begin
        int   gap;
        logic acc;
        frame_stall = 1'b0;
        forever
        begin
            gap = sink_no_gap ? 0 : $urandom_range(0, 5);
            if (gap > 0)
            begin
                frame_stall <= 1'b1;
                repeat (gap) @(posedge clk);
            end
            frame_stall <= 1'b0;
            do
            begin
                @(negedge clk);
                acc = (frame_valid === 1'b1) && (frame_stall === 1'b0);
                @(posedge clk);
            end
            while (!acc);
        end
    end

    always @(negedge clk)
    begin
        frame_word_t w;
        if (rst_n === 1'b1 && frame_valid === 1'b1 && frame_stall === 1'b0)
        begin
            if (expected_words.size() == 0)
            begin
                $error("unexpected frame word: byte %h last %b length %0d overflow %b",
                       frame_byte, frame_last, frame_length, overflow);
                fail_count++;
            end
            else
            begin
                w = expected_words.pop_front();
                if (frame_byte !== w.data)
                begin
                    $error("frame_byte: expected %h, actual %h", w.data, frame_byte);
                    fail_count++;
                end
                if (frame_last !== w.last)
                begin
                    $error("frame_last: expected %b, actual %b", w.last, frame_last);
                    fail_count++;
                end
                if (frame_length !== w.len)
                begin
                    $error("frame_length: expected %0d, actual %0d", w.len, frame_length);
                    fail_count++;
                end
                if (overflow !== w.ovf)
                begin
                    $error("overflow: expected %b, actual %b", w.ovf, overflow);
                    fail_count++;
                end
            end
        end
    end

    task automatic test_idle_terminators();
        send_byte(CHAR_CR);
        send_byte(CHAR_LF);
        send_byte(CHAR_CR);
        send_byte(CHAR_LF);
    endtask

    task automatic test_short_lines();
        send_byte(8'h00);
        send_byte(CHAR_CR);
        send_byte(8'hFF);
        send_byte(CHAR_LF);
        send_byte(8'h0C);
        send_byte(8'h0B);
        send_byte(8'h0E);
        send_byte(8'h09);
        send_byte(8'h80);
        send_byte(8'h7F);
        send_byte(CHAR_CR);
        send_byte(CHAR_LF);
    endtask

    task automatic test_full_line();
        int i;
        rx_no_gap   = 1'b1;
        sink_no_gap = 1'b1;
        for (i = 0; i < MAX_LINE; i++)
            send_byte(BYTE_W'(8'hE0 ^ (i * 37)) == CHAR_CR ? 8'h55 :
                      BYTE_W'(8'hE0 ^ (i * 37)) == CHAR_LF ? 8'hAA :
                      BYTE_W'(8'hE0 ^ (i * 37)));
        send_byte(CHAR_CR);
        rx_no_gap   = 1'b0;
        sink_no_gap = 1'b0;
    endtask

    task automatic test_overflow();
        send_line(MAX_LINE + 3, CHAR_LF);
        send_byte(8'h41);
        send_byte(CHAR_CR);
        send_line(MAX_LINE + 1, CHAR_CR);
    endtask

    task automatic test_random_lines();
        int base;
        int kind;
        int i;
        base = taken_items;
        while (taken_items - base < RAND_ITEMS)
        begin
            rx_no_gap   = ($urandom_range(0, 7) == 0);
            sink_no_gap = ($urandom_range(0, 7) == 0);
            kind = $urandom_range(0, 9);
            if (kind == 0)
            begin
                for (i = 0; i < 4; i++)
                    send_byte(BYTE_W'($urandom_range(0, 255)));
            end
            else if (kind == 1)
            begin
                send_line($urandom_range(MAX_LINE - 2, MAX_LINE + 6),
                          $urandom_range(0, 1) ? CHAR_CR : CHAR_LF);
            end
            else
            begin
                send_line($urandom_range(1, 8), $urandom_range(0, 1) ? CHAR_CR : CHAR_LF);
                if ($urandom_range(0, 3) == 0)
                    send_byte($urandom_range(0, 1) ? CHAR_CR : CHAR_LF);
            end
        end
        rx_no_gap   = 1'b0;
        sink_no_gap = 1'b0;
    endtask

    initial
    begin
        rst_n       = 1'b0;
        rx_valid    = 1'b0;
        rx_byte     = '0;
        rx_no_gap   = 1'b0;
        sink_no_gap = 1'b0;
        held_count  = 0;
        overflowed  = 1'b0;
        taken_items = 0;
        fail_count  = 0;
        cycle_count = 0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        test_idle_terminators();
        test_short_lines();
        test_full_line();
        test_overflow();
        test_random_lines();

        rx_valid <= 1'b0;
        while (expected_words.size() != 0)
            @(posedge clk);
        repeat (2 * MAX_LINE + 8) @(posedge clk);

        if (fail_count == 0 && expected_words.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

// File: crlf_line_framer.f
src/clf_pkg.sv
src/clf_line_ram.sv
src/crlf_line_framer.sv
test/tb_top.sv
